FILE: rtl/slnt_pkg.sv
// Package for the sorted leaf node table.
// Holds field widths, action and status codes, transaction structs and the sequencer states.
// No dependencies.
`default_nettype none

package slnt_pkg;

    localparam int NODE_CAPACITY_DEF = 64;
    localparam int ACT_W             = 2;
    localparam int ST_W              = 2;
    localparam int KEY_W             = 32;
    localparam int REC_W             = 64;
    localparam int CNT_W             = 7;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SPLIT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOCATE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [KEY_W-1:0] key_in;
        logic [REC_W-1:0]        record_in;
        logic [CNT_W-1:0]        entry_index;
    } in_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [CNT_W-1:0]        index_out;
        logic signed [KEY_W-1:0] key_out;
        logic [REC_W-1:0]        record_out;
        logic [CNT_W-1:0]        entries_now;
        logic                    entry_valid;
        logic                    last;
    } out_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [REC_W-1:0]        record;
    } entry_t;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_CMP  = 9'b000000010,
        S_INS_PUT  = 9'b000000100,
        S_SPL_RD   = 9'b000001000,
        S_SPL_LOAD = 9'b000010000,
        S_LOC_CMP  = 9'b000100000,
        S_RD_LOAD  = 9'b001000000,
        S_RESULT   = 9'b010000000,
        S_UNUSED   = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/slnt_mem.sv
// Entry store of the sorted leaf node table: one write port, one registered read port.
// Depends on slnt_pkg for the entry struct.
`default_nettype none

module slnt_mem
    import slnt_pkg::*;
#(
    parameter int DEPTH  = NODE_CAPACITY_DEF + 1,
    parameter int ADDR_W = $clog2(NODE_CAPACITY_DEF + 1)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/sorted_leaf_node_table.sv
// Sorted leaf node table: key-ordered entry store with insert, split, locate and read.
// Insert: shifts each larger entry up one slot (one entry moved per cycle), then the result.
// Split: an insert, then one moved-out entry per cycle as results are taken.
// Locate scans from the first entry; read fetches one entry by index. One transaction at a time.
// Reset clears the entry count and handshake state; the entry store itself is not cleared.
`default_nettype none

module sorted_leaf_node_table
    import slnt_pkg::*;
#(
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    localparam int SLOTS  = NODE_CAPACITY + 1;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(NODE_CAPACITY);
    localparam logic [CNT_W-1:0] SLOT_C = CNT_W'(SLOTS);

    state_t                  state_reg, state_next;
    logic [ACT_W-1:0]        act_reg, act_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [REC_W-1:0]        rec_reg, rec_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        end_reg, end_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic [ST_W-1:0]         res_st_reg, res_st_next;
    logic [CNT_W-1:0]        res_idx_reg, res_idx_next;
    out_t                    out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    logic [CNT_W-1:0] rd_idx;
    logic [CNT_W-1:0] wr_idx;
    logic             wr_en;
    entry_t           wr_data;
    entry_t           rd_data;
    logic             out_free;
    logic             load;
    out_t             load_data;
    logic             key_lt;
    logic             key_eq;
    logic             key_gt;
    logic [CNT_W-1:0] grown;
    logic [CNT_W-1:0] keep;

    slnt_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    assign key_lt = rd_data.key < key_reg;
    assign key_eq = rd_data.key == key_reg;
    assign key_gt = !key_lt && !key_eq;

    assign grown    = total_reg + 7'd1;
    assign keep     = (grown >> 1) + 7'd1;
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        rec_next       = rec_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        total_next     = total_reg;
        res_st_next    = res_st_reg;
        res_idx_next   = res_idx_reg;
        rd_idx         = idx_reg;
        wr_en          = 1'b0;
        wr_idx         = idx_reg;
        wr_data.key    = key_reg;
        wr_data.record = rec_reg;
        load           = 1'b0;
        load_data      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = in_data.action;
                    key_next     = in_data.key_in;
                    rec_next     = in_data.record_in;
                    res_idx_next = '0;
                    case (in_data.action)
                        ACT_INSERT, ACT_SPLIT:
                        begin
                            if ((in_data.action == ACT_INSERT && total_reg >= CAP_C) ||
                                (in_data.action == ACT_SPLIT && total_reg >= SLOT_C))
                            begin
                                res_st_next = ST_FULL;
                                state_next  = S_RESULT;
                            end
                            else if (total_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                idx_next   = total_reg - 7'd1;
                                rd_idx     = total_reg - 7'd1;
                                state_next = S_INS_CMP;
                            end
                        end
                        ACT_LOCATE:
                        begin
                            if (total_reg == '0)
                            begin
                                res_st_next  = ST_NOT_FOUND;
                                res_idx_next = 7'd1;
                                state_next   = S_RESULT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                rd_idx     = '0;
                                state_next = S_LOC_CMP;
                            end
                        end
                        default:
                        begin
                            if (in_data.entry_index == '0 || in_data.entry_index > total_reg)
                            begin
                                res_st_next = ST_BAD_INDEX;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                idx_next   = in_data.entry_index - 7'd1;
                                rd_idx     = in_data.entry_index - 7'd1;
                                state_next = S_RD_LOAD;
                            end
                        end
                    endcase
                end
            end

            S_INS_CMP:
            begin
                rd_idx = idx_reg - 7'd1;
                if (key_gt)
                begin
                    wr_en   = 1'b1;
                    wr_idx  = idx_reg + 7'd1;
                    wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        idx_next = idx_reg - 7'd1;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 7'd1;
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT:
            begin
                wr_en       = 1'b1;
                res_st_next = ST_OK;
                total_next  = grown;
                state_next  = S_RESULT;
                if (act_reg == ACT_SPLIT && keep < grown)
                begin
                    total_next = keep;
                    idx_next   = keep;
                    end_next   = grown;
                    state_next = S_SPL_RD;
                end
            end

            S_SPL_RD:
            begin
                state_next = S_SPL_LOAD;
            end

            S_SPL_LOAD:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    load_data.status      = ST_OK;
                    load_data.key_out     = rd_data.key;
                    load_data.record_out  = rd_data.record;
                    load_data.entries_now = total_reg;
                    load_data.entry_valid = 1'b1;
                    load_data.last        = (idx_reg + 7'd1) == end_reg;
                    rd_idx                = idx_reg + 7'd1;
                    idx_next              = idx_reg + 7'd1;
                    if ((idx_reg + 7'd1) == end_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_LOC_CMP:
            begin
                rd_idx = idx_reg + 7'd1;
                if (!key_lt)
                begin
                    res_st_next  = key_eq ? ST_OK : ST_NOT_FOUND;
                    res_idx_next = idx_reg + 7'd1;
                    state_next   = S_RESULT;
                end
                else if ((idx_reg + 7'd1) == total_reg)
                begin
                    res_st_next  = ST_NOT_FOUND;
                    res_idx_next = total_reg + 7'd1;
                    state_next   = S_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + 7'd1;
                end
            end

            S_RD_LOAD:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    load_data.status      = ST_OK;
                    load_data.key_out     = rd_data.key;
                    load_data.record_out  = rd_data.record;
                    load_data.entries_now = total_reg;
                    load_data.entry_valid = 1'b1;
                    load_data.last        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    load_data.status      = res_st_reg;
                    load_data.index_out   = res_idx_reg;
                    load_data.entries_now = total_reg;
                    load_data.last        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_next       = load_data;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        key_reg     <= key_next;
        rec_reg     <= rec_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        res_st_reg  <= res_st_next;
        res_idx_reg <= res_idx_next;
        out_reg     <= out_next;
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CAP_C)
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_idx <= CAP_C)
        else $error("entry store write beyond last slot");

    a_split_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPL_LOAD |-> (idx_reg < end_reg && idx_reg >= total_reg))
        else $error("split emit index outside moved-out range");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == S_RESULT) |=> state_reg == S_RESULT)
        else $error("result left while output slot busy");

endmodule

`default_nettype wire

FILE: tb/leaf_table_checker.sv
// Checker for the sorted leaf node table: watches both channels, keeps its own copy of the
// key-ordered entry table, predicts every result and compares it field by field.
// Depends on slnt_pkg for the transaction structs, action and status codes.
`timescale 1ns / 1ps

module leaf_table_checker
    import slnt_pkg::*;
#(
    parameter int CAPACITY = NODE_CAPACITY_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_ready,
    input  wire in_t  in_data,
    input  wire logic out_valid,
    input  wire logic out_ready,
    input  wire out_t out_data,
    output int        fail_count,
    output int        outstanding,
    output int        held_entries,
    output int        items_seen,
    output int        results_seen
);

    logic signed [KEY_W-1:0] table_keys    [0:CAPACITY];
    logic [REC_W-1:0]        table_records [0:CAPACITY];
    int                      held;
    int                      fails;
    int                      items;
    int                      results;
    out_t                    pending_results [$];

    function automatic out_t make_result(logic [ST_W-1:0] st, logic [CNT_W-1:0] idx,
                                         logic signed [KEY_W-1:0] k, logic [REC_W-1:0] rec,
                                         logic valid, logic fin);
        out_t r;
        r.status      = st;
        r.index_out   = idx;
        r.key_out     = k;
        r.record_out  = rec;
        r.entries_now = CNT_W'(held);
        r.entry_valid = valid;
        r.last        = fin;
        return r;
    endfunction

    function automatic void place_entry(logic signed [KEY_W-1:0] k, logic [REC_W-1:0] rec);
        int pos;
        int i;
        pos = held;
        for (i = 0; i < held; i++)
        begin
            if (table_keys[i] > k)
            begin
                pos = i;
                break;
            end
        end
        for (i = held; i > pos; i--)
        begin
            table_keys[i]    = table_keys[i-1];
            table_records[i] = table_records[i-1];
        end
        table_keys[pos]    = k;
        table_records[pos] = rec;
        held++;
    endfunction

    function automatic void apply_action(in_t t);
        int   n;
        int   keep;
        int   i;
        logic found;
        case (t.action)
            ACT_INSERT:
            begin
                if (held >= CAPACITY)
                    pending_results.push_back(make_result(ST_FULL, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    place_entry(t.key_in, t.record_in);
                    pending_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 1'b1));
                end
            end
            ACT_SPLIT:
            begin
                if (held >= CAPACITY + 1)
                    pending_results.push_back(make_result(ST_FULL, '0, '0, '0, 1'b0, 1'b1));
                else
                begin
                    place_entry(t.key_in, t.record_in);
                    n    = held;
                    keep = n / 2 + 1;
                    if (keep >= n)
                        pending_results.push_back(make_result(ST_OK, '0, '0, '0, 1'b0, 1'b1));
                    else
                    begin
                        held = keep;
                        for (i = keep; i < n; i++)
                            pending_results.push_back(make_result(ST_OK, '0, table_keys[i],
                                table_records[i], 1'b1, i == n - 1));
                    end
                end
            end
            ACT_LOCATE:
            begin
                found = 1'b0;
                for (i = 0; i < held; i++)
                begin
                    if (!(t.key_in > table_keys[i]))
                    begin
                        pending_results.push_back(make_result(
                            (table_keys[i] == t.key_in) ? ST_OK : ST_NOT_FOUND,
                            CNT_W'(i + 1), '0, '0, 1'b0, 1'b1));
                        found = 1'b1;
                        break;
                    end
                end
                if (!found)
                    pending_results.push_back(make_result(ST_NOT_FOUND, CNT_W'(held + 1),
                        '0, '0, 1'b0, 1'b1));
            end
            default:
            begin
                if (t.entry_index == 0 || t.entry_index > held)
                    pending_results.push_back(make_result(ST_BAD_INDEX, '0, '0, '0, 1'b0, 1'b1));
                else
                    pending_results.push_back(make_result(ST_OK, '0,
                        table_keys[t.entry_index - 1], table_records[t.entry_index - 1],
                        1'b1, 1'b1));
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            held    = 0;
            fails   = 0;
            items   = 0;
            results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results++;
                if (pending_results.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: unexpected result st=%0d idx=%0d key=%0d rec=%h n=%0d",
                                 $time, out_data.status, out_data.index_out, out_data.key_out,
                                 out_data.record_out, out_data.entries_now);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.status !== want.status
                        || out_data.index_out !== want.index_out
                        || out_data.key_out !== want.key_out
                        || out_data.record_out !== want.record_out
                        || out_data.entries_now !== want.entries_now
                        || out_data.entry_valid !== want.entry_valid
                        || out_data.last !== want.last)
                    begin
                        if (fails < 10)
                        begin
                            $display("%0t: result %0d mismatch", $time, results);
                            $display("  expected st=%0d idx=%0d key=%0d rec=%h n=%0d v=%0b l=%0b",
                                     want.status, want.index_out, want.key_out,
                                     want.record_out, want.entries_now, want.entry_valid,
                                     want.last);
                            $display("  actual   st=%0d idx=%0d key=%0d rec=%h n=%0d v=%0b l=%0b",
                                     out_data.status, out_data.index_out, out_data.key_out,
                                     out_data.record_out, out_data.entries_now,
                                     out_data.entry_valid, out_data.last);
                        end
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items++;
                apply_action(in_data);
            end
        end
        fail_count   <= fails;
        outstanding  <= pending_results.size();
        held_entries <= held;
        items_seen   <= items;
        results_seen <= results;
    end

endmodule

FILE: tb/sorted_leaf_node_table_tb.sv
// Top of the sorted leaf node table testbench: clock, reset, stimulus and the verdict.
// Drives directed and random insert, split, locate and read transactions under several
// idle profiles; depends on slnt_pkg, the block and leaf_table_checker.
`timescale 1ns / 1ps

module sorted_leaf_node_table_tb;
    import slnt_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 150;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    int   fail_count;
    int   outstanding;
    int   held_entries;
    int   items_seen;
    int   results_seen;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_req;

    sorted_leaf_node_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    leaf_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .held_entries (held_entries),
        .items_seen   (items_seen),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin : receiver
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req === 1'b1 && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic in_t make_item(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] k,
                                      logic [REC_W-1:0] rec, logic [CNT_W-1:0] idx);
        in_t t;
        t.action      = act;
        t.key_in      = k;
        t.record_in   = rec;
        t.entry_index = idx;
        return t;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return KEY_MIN;
        if (sel < 16)
            return KEY_MAX;
        if (sel < 20)
            return '0;
        if (sel < 24)
            return -1;
        if (sel < 60)
            return KEY_W'($urandom_range(0, 31)) - 16;
        return $urandom;
    endfunction

    function automatic in_t random_item();
        int               sel;
        logic [ACT_W-1:0] act;
        logic [CNT_W-1:0] idx;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            act = ACT_INSERT;
        else if (sel < 62)
            act = ACT_SPLIT;
        else if (sel < 81)
            act = ACT_LOCATE;
        else
            act = ACT_READ;
        if (act == ACT_READ && held_entries > 0 && $urandom_range(0, 99) < 70)
            idx = CNT_W'($urandom_range(1, held_entries));
        else
            idx = CNT_W'($urandom_range(0, 127));
        return make_item(act, pick_key(), {$urandom, $urandom}, idx);
    endfunction

    task automatic send_item(input in_t item);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count)
            send_item(random_item());
        drain();
    endtask

    initial
    begin : stimulus
        int i;
        hold_req = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty node: bad indexes, locate past the end, small splits (the third moves one entry out)
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd0));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd1));
        send_item(make_item(ACT_LOCATE, 32'sd5,    64'h0, 7'd0));
        send_item(make_item(ACT_SPLIT,  32'sd100,  64'h1111_0000_0000_0100, 7'd0));
        send_item(make_item(ACT_SPLIT,  -32'sd100, 64'h2222_0000_0000_0200, 7'd0));
        send_item(make_item(ACT_SPLIT,  32'sd50,   64'h3333_0000_0000_0300, 7'd0));
        send_item(make_item(ACT_LOCATE, 32'sd1000, 64'h0, 7'd0));
        // extremes and equal keys
        send_item(make_item(ACT_INSERT, KEY_MIN,   {REC_W{1'b1}}, 7'd127));
        send_item(make_item(ACT_INSERT, KEY_MAX,   64'h0, 7'd0));
        send_item(make_item(ACT_INSERT, 32'sd50,   64'haaaa_aaaa_aaaa_aaaa, 7'd0));
        send_item(make_item(ACT_INSERT, 32'sd50,   64'h5555_5555_5555_5555, 7'd0));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd1));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd3));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd4));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd5));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd6));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd7));
        send_item(make_item(ACT_READ,   32'sd0,    64'h0, 7'd127));
        send_item(make_item(ACT_LOCATE, 32'sd50,   64'h0, 7'd0));
        send_item(make_item(ACT_LOCATE, 32'sd0,    64'h0, 7'd0));
        send_item(make_item(ACT_LOCATE, KEY_MIN,   64'h0, 7'd0));
        send_item(make_item(ACT_LOCATE, KEY_MAX,   64'h0, 7'd0));
        send_item(make_item(ACT_SPLIT,  -32'sd1,   64'h0123_4567_89ab_cdef, 7'd0));
        drain();

        // fill to capacity, hit full rejects, then split the full node
        idle_pct  = 0;
        stall_pct = 0;
        for (i = 0; i < 68; i++)
        begin
            if (i == 10)
                hold_req = 1'b1;
            send_item(make_item(ACT_INSERT, pick_key(), {$urandom, $urandom},
                                CNT_W'($urandom_range(0, 127))));
        end
        send_item(make_item(ACT_SPLIT, pick_key(), {$urandom, $urandom}, 7'd0));
        drain();

        run_random(60, 63, 0);
        run_random(60, 0, 63);
        run_random(60, 9, 9);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d transactions and checked %0d results: inserts up to a full node,",
                 items_seen, results_seen);
        $display("splits from empty to full, locates and reads under four idle profiles.");
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
